@@ rtl/tpg_pkg.sv @@
// Shared constants and types for the top pooling block.
// Used by tpg_regs, tpg_col_update, the top level and tpg_checker; depends on nothing.
package tpg_pkg;

  // Defaults for the top level parameters
  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int VALUE_BITS_DEF  = 16;

  // Gradient sums carry eight more integer bits than the inputs
  localparam int GRAD_EXTRA = 8;

  // Reset height of the pooled dimension
  localparam int ROWS_RESET = 64;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  // How an item ends the open run of its column
  typedef struct packed {
    logic closed;  // strictly greater value closed the previous run
    logic flush;   // row zero flushes the run
  } upd_ctl_t;

endpackage

@@ rtl/tpg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/tpg_regs.sv @@
// Configuration registers behind the APB-style port.
// Depends on tpg_pkg for the register index and port widths.
module tpg_regs #(
  parameter int MAX_COLUMNS = tpg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tpg_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpg_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tpg_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [$clog2(MAX_ROWS + 1)-1:0]     rows_in_use,
  output logic [$clog2(MAX_COLUMNS + 1)-1:0]  columns_in_use
);

  localparam int RIU_W = $clog2(MAX_ROWS + 1);
  localparam int CIU_W = $clog2(MAX_COLUMNS + 1);

  logic [RIU_W-1:0] rows_r;
  logic [CIU_W-1:0] cols_r;
  logic             wr_fire;
  tpg_pkg::reg_idx_t sel;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign sel     = tpg_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RIU_W'(tpg_pkg::ROWS_RESET);
      cols_r <= CIU_W'(MAX_COLUMNS);
    end else if (wr_fire) begin
      unique case (sel)
        tpg_pkg::REG_ROWS: rows_r <= pwdata[RIU_W-1:0];
        tpg_pkg::REG_COLS: cols_r <= pwdata[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      tpg_pkg::REG_ROWS: prdata = tpg_pkg::CFG_DATA_W'(rows_r);
      tpg_pkg::REG_COLS: prdata = tpg_pkg::CFG_DATA_W'(cols_r);
      default:           prdata = '0;
    endcase
  end

  assign rows_in_use    = rows_r;
  assign columns_in_use = cols_r;

endmodule

@@ rtl/tpg_col_update.sv @@
// Per-column run update: new max/row/sum and the one or two packed results.
// Depends on tpg_pkg for the control struct.
module tpg_col_update #(
  parameter int VALUE_BITS = tpg_pkg::VALUE_BITS_DEF,
  parameter int ROW_W      = 10,
  parameter int RES_W      = VALUE_BITS + ROW_W + VALUE_BITS + tpg_pkg::GRAD_EXTRA + 2
) (
  input  logic signed [VALUE_BITS-1:0]                       cur_max,
  input  logic        [ROW_W-1:0]                            cur_row,
  input  logic signed [VALUE_BITS+tpg_pkg::GRAD_EXTRA-1:0]   cur_sum,
  input  logic                                               is_first,
  input  logic        [ROW_W-1:0]                            row,
  input  logic signed [VALUE_BITS-1:0]                       value,
  input  logic signed [VALUE_BITS-1:0]                       backprop,
  output logic signed [VALUE_BITS-1:0]                       new_max,
  output logic        [ROW_W-1:0]                            new_row,
  output logic signed [VALUE_BITS+tpg_pkg::GRAD_EXTRA-1:0]   new_sum,
  output tpg_pkg::upd_ctl_t                                  ctl,
  output logic        [RES_W-1:0]                            res0,
  output logic        [RES_W-1:0]                            res1
);

  localparam int GRAD_W = VALUE_BITS + tpg_pkg::GRAD_EXTRA;

  logic signed [GRAD_W:0]   acc;
  logic signed [GRAD_W-1:0] acc_sat;
  logic                     greater;
  logic [RES_W-1:0]         flush_res;

  assign acc     = $signed({cur_sum[GRAD_W-1], cur_sum}) + (GRAD_W + 1)'(backprop);
  assign greater = value > cur_max;

  // Clamp on overflow of the sum
  always_comb begin
    if (acc[GRAD_W] != acc[GRAD_W-1]) begin
      acc_sat = acc[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end else begin
      acc_sat = acc[GRAD_W-1:0];
    end
  end

  always_comb begin
    if (is_first || greater) begin
      new_max = value;
      new_row = row;
      new_sum = GRAD_W'(backprop);
    end else begin
      new_max = cur_max;
      new_row = cur_row;
      new_sum = acc_sat;
    end
  end

  assign ctl.closed = !is_first && greater;
  assign ctl.flush  = (row == '0);

  // Result layout: {pooled, grad_valid, grad_row, grad_value, last}
  assign flush_res = {new_max, 1'b1, new_row, new_sum, 1'b1};

  always_comb begin
    if (ctl.closed) begin
      res0 = {value, 1'b1, cur_row, cur_sum, !ctl.flush};
    end else if (ctl.flush) begin
      res0 = flush_res;
    end else begin
      res0 = {new_max, 1'b0, ROW_W'(0), GRAD_W'(0), 1'b1};
    end
  end

  assign res1 = flush_res;

endmodule

@@ rtl/tpg_out_buf.sv @@
// Two-entry result buffer: output register plus a slot for the second result.
// No dependencies.
module tpg_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             push_two,
  input  logic [WIDTH-1:0] data0,
  input  logic [WIDTH-1:0] data1,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             v0_r, v1_r;
  logic [WIDTH-1:0] d0_r, d1_r;
  logic             fire;

  assign fire  = v0_r && !out_stall;
  // Room when empty, or once the current head leaves and nothing is queued behind it
  assign ready = !v0_r || (fire && !v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (push) begin
      v0_r <= 1'b1;
      v1_r <= push_two;
    end else if (fire) begin
      v0_r <= v1_r;
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      d0_r <= data0;
      d1_r <= data1;
    end else if (fire) begin
      d0_r <= d1_r;
    end
  end

  assign out_valid = v0_r;
  assign out_data  = d0_r;

endmodule

@@ rtl/top_pool_with_gradient.sv @@
// Top pooling with gradient, streamed per column: top level.
// Uses tpg_pkg, tpg_regs, tpg_ram, tpg_col_update and tpg_out_buf.
//
// Usage:
//   Input channel (in_*): one element per transaction: column, row, value
//   and its incoming gradient. Rows of a column arrive from the bottom row
//   (rows_in_use-1) up to row 0. Items outside the configured columns or
//   rows are taken and dropped without a result.
//   Result channel (out_*): one or two results per item, the last marked by
//   out_last_result. A closed run comes before the row-zero flush.
//   The item is first registered in the working stage; its result is then
//   registered in the output buffer, where it can be taken. Throughput: one
//   item per cycle while no result is stalled; an item that both closes a
//   run and flushes holds back the next item until its second result is taken.
//   Per-column state lives in a MAX_COLUMNS-deep RAM read at acceptance and
//   written as the item leaves the working stage; a back-to-back item on the
//   same column takes the new state from a forwarding register.
//   Reset: clears the pipeline and loads rows_in_use=64 and
//   columns_in_use=MAX_COLUMNS; column state is undefined until a column's
//   first row is seen. No clearing pass.
//   Stall: a stalled result holds; the block takes at most one more item into
//   its working stage and then raises in_stall.
module top_pool_with_gradient #(
  parameter int MAX_COLUMNS = tpg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tpg_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS  = tpg_pkg::VALUE_BITS_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      in_valid,
  output logic                                                      in_stall,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0]  in_column_index,
  input  logic [$clog2(MAX_ROWS)-1:0]                               in_row_index,
  input  logic signed [VALUE_BITS-1:0]                              in_value,
  input  logic signed [VALUE_BITS-1:0]                              in_backprop_value,
  output logic                                                      out_valid,
  input  logic                                                      out_stall,
  output logic signed [VALUE_BITS-1:0]                              out_pooled_value,
  output logic                                                      out_grad_valid,
  output logic [$clog2(MAX_ROWS)-1:0]                               out_grad_row,
  output logic signed [VALUE_BITS+tpg_pkg::GRAD_EXTRA-1:0]          out_grad_value,
  output logic                                                      out_last_result,
  input  logic                                                      psel,
  input  logic                                                      penable,
  input  logic                                                      pwrite,
  input  logic [tpg_pkg::CFG_ADDR_W-1:0]                            paddr,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]                            pwdata,
  output logic [tpg_pkg::CFG_DATA_W-1:0]                            prdata,
  output logic                                                      pready
);

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int RIU_W  = $clog2(MAX_ROWS + 1);
  localparam int CIU_W  = $clog2(MAX_COLUMNS + 1);
  localparam int GRAD_W = VALUE_BITS + tpg_pkg::GRAD_EXTRA;
  localparam int ST_W   = VALUE_BITS + ROW_W + GRAD_W;
  localparam int RES_W  = VALUE_BITS + 1 + ROW_W + GRAD_W + 1;

  logic [RIU_W-1:0] rows_in_use;
  logic [CIU_W-1:0] columns_in_use;

  tpg_regs #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rows_in_use    (rows_in_use),
    .columns_in_use (columns_in_use)
  );

  // Effective last row index of a column (bottom row, arrives first)
  logic [ROW_W-1:0] last_row;
  always_comb begin
    if (rows_in_use == '0) begin
      last_row = '0;
    end else if (rows_in_use > RIU_W'(MAX_ROWS)) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(rows_in_use - RIU_W'(1));
    end
  end

  logic in_fire, in_keep, buf_ready, s1_adv;

  assign in_fire = in_valid && !in_stall;
  assign in_keep = (CIU_W'(in_column_index) < columns_in_use) &&
                   (CIU_W'(in_column_index) < CIU_W'(MAX_COLUMNS)) &&
                   (in_row_index <= last_row);

  // Working stage
  logic                         s1_valid_r;
  logic [COL_W-1:0]             s1_col_r;
  logic [ROW_W-1:0]             s1_row_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;
  logic signed [VALUE_BITS-1:0] s1_bp_r;

  assign s1_adv   = s1_valid_r && buf_ready;
  assign in_stall = s1_valid_r && !buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= in_keep;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r <= in_column_index;
      s1_row_r <= in_row_index;
      s1_val_r <= in_value;
      s1_bp_r  <= in_backprop_value;
    end
  end

  // Column state RAM and forwarding of the write that lands with the read
  logic [ST_W-1:0] ram_rd, new_state, cur_state;
  logic            fwd_hit_r;
  logic [ST_W-1:0] fwd_state_r;

  tpg_ram #(
    .WIDTH (ST_W),
    .DEPTH (MAX_COLUMNS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (new_state),
    .rd_en   (in_fire),
    .rd_addr (in_column_index),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= s1_adv && (s1_col_r == in_column_index);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_state_r <= new_state;
    end
  end

  assign cur_state = fwd_hit_r ? fwd_state_r : ram_rd;

  logic signed [VALUE_BITS-1:0] new_max;
  logic        [ROW_W-1:0]      new_row;
  logic signed [GRAD_W-1:0]     new_sum;
  tpg_pkg::upd_ctl_t            ctl;
  logic [RES_W-1:0]             res0, res1, out_data;

  tpg_col_update #(
    .VALUE_BITS (VALUE_BITS),
    .ROW_W      (ROW_W),
    .RES_W      (RES_W)
  ) u_update (
    .cur_max  (cur_state[ST_W-1 -: VALUE_BITS]),
    .cur_row  (cur_state[GRAD_W +: ROW_W]),
    .cur_sum  (cur_state[GRAD_W-1:0]),
    .is_first (s1_row_r == last_row),
    .row      (s1_row_r),
    .value    (s1_val_r),
    .backprop (s1_bp_r),
    .new_max  (new_max),
    .new_row  (new_row),
    .new_sum  (new_sum),
    .ctl      (ctl),
    .res0     (res0),
    .res1     (res1)
  );

  assign new_state = {new_max, new_row, new_sum};

  tpg_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_adv),
    .push_two  (ctl.closed && ctl.flush),
    .data0     (res0),
    .data1     (res1),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_pooled_value = out_data[RES_W-1 -: VALUE_BITS];
  assign out_grad_valid   = out_data[1 + GRAD_W + ROW_W];
  assign out_grad_row     = out_data[1 + GRAD_W +: ROW_W];
  assign out_grad_value   = out_data[1 +: GRAD_W];
  assign out_last_result  = out_data[0];

endmodule

@@ rtl/tpg_checker.sv @@
// Port-level assertions for top_pool_with_gradient and the bind that attaches them.
// Depends on tpg_pkg for default widths.
module tpg_checker #(
  parameter int MAX_ROWS   = tpg_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = tpg_pkg::VALUE_BITS_DEF
) (
  input logic                                              clk,
  input logic                                              rst_n,
  input logic                                              out_valid,
  input logic                                              out_stall,
  input logic signed [VALUE_BITS-1:0]                      out_pooled_value,
  input logic                                              out_grad_valid,
  input logic [$clog2(MAX_ROWS)-1:0]                       out_grad_row,
  input logic signed [VALUE_BITS+tpg_pkg::GRAD_EXTRA-1:0]  out_grad_value,
  input logic                                              out_last_result
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result without a gradient carries zero row and value and ends its item
  a_no_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grad_valid |->
      out_grad_row == '0 && out_grad_value == '0 && out_last_result)
    else $error("non-gradient result malformed");

  // The first of two results is a closed run
  a_first_is_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_grad_valid)
    else $error("non-final result without gradient");

  // The flush follows a closed run at once
  a_flush_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_result |=>
      out_valid && out_grad_valid && out_last_result)
    else $error("second result of an item missing");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pooled_value) &&
      $stable(out_grad_value) && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind top_pool_with_gradient tpg_checker #(
  .MAX_ROWS   (MAX_ROWS),
  .VALUE_BITS (VALUE_BITS)
) u_tpg_checker (.*);
